>>> src/tksq_pkg.sv
// Shared types and constants for the two-key sorted priority queue.
`timescale 1ns / 1ps

package tksq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TAG_W = 16;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned DUR_W = 16;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned STA_W = 2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [STA_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STA_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STA_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PRI_W-1:0] prio;
    logic [DUR_W-1:0] dur;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ent;
  } ctrl_t;

endpackage

>>> src/two_key_sorted_priority_queue.sv
// Top level of the two-key sorted priority queue: cell chain, count and result register.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one operation per transfer:
//   mode_i = enqueue puts entry_tag_i/entry_priority_i/entry_duration_i in sorted
//   place, mode_i = dequeue takes the head (the entry fields are ignored then).
//   Order: smaller priority first, then shorter duration; a new entry goes ahead
//   of equal ones.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result per
//   operation: status, the removed entry (zero unless a dequeue succeeded) and
//   the occupancy after the operation.
//   Timing: the result is registered and valid in the cycle after the input transfer.
//   Throughput: one operation per cycle unless the output stalls; every cell compares its slot with the
//   new entry and shifts in the same cycle, so nothing iterates.
//   Stall: the result register holds while out_ready_i is low; a new input is
//   taken only when that register is empty or being emptied in the same cycle.
//   Reset: all slots read empty, count zero, no result pending.
//   Enqueue when full gives status full, dequeue when empty gives status empty;
//   neither changes the queue.

module two_key_sorted_priority_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [tksq_pkg::TAG_W-1:0] entry_tag_i,
  input  logic [tksq_pkg::PRI_W-1:0] entry_priority_i,
  input  logic [tksq_pkg::DUR_W-1:0] entry_duration_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tksq_pkg::STA_W-1:0] status_o,
  output logic [tksq_pkg::TAG_W-1:0] removed_tag_o,
  output logic [tksq_pkg::PRI_W-1:0] removed_priority_o,
  output logic [tksq_pkg::DUR_W-1:0] removed_duration_o,
  output logic [tksq_pkg::OCC_W-1:0] occupancy_o
);

  localparam int unsigned N = tksq_pkg::QUEUE_DEPTH;

  logic                       accept;
  logic                       full, empty;
  tksq_pkg::ctrl_t            ctrl;
  logic [tksq_pkg::CNT_W-1:0] count_q, count_d;

  logic                       out_valid_q;
  logic [tksq_pkg::STA_W-1:0] status_q, status_d;
  tksq_pkg::entry_t           removed_q, removed_d;
  logic [tksq_pkg::OCC_W-1:0] occ_q;

  logic             ahead [N];
  logic             valid [N];
  tksq_pkg::entry_t entry [N];

  // result register frees up on the same edge it is read
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == tksq_pkg::CNT_W'(N));
  assign empty = (count_q == '0);

  assign ctrl.push     = accept && (mode_i == tksq_pkg::MODE_ENQ) && !full;
  assign ctrl.pop      = accept && (mode_i == tksq_pkg::MODE_DEQ) && !empty;
  assign ctrl.ent.tag  = entry_tag_i;
  assign ctrl.ent.prio = entry_priority_i;
  assign ctrl.ent.dur  = entry_duration_i;

  // slot 0 is the head; data moves right on enqueue, left on dequeue
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic             l_ahead, l_valid, r_valid;
    tksq_pkg::entry_t l_entry, r_entry;

    if (i == 0) begin : g_head
      assign l_ahead = 1'b1;
      assign l_valid = 1'b1;
      assign l_entry = ctrl.ent;
    end else begin : g_body
      assign l_ahead = ahead[i-1];
      assign l_valid = valid[i-1];
      assign l_entry = entry[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = '0;
    end else begin : g_mid
      assign r_valid = valid[i+1];
      assign r_entry = entry[i+1];
    end

    tksq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_ahead_i (l_ahead),
      .left_valid_i (l_valid),
      .left_entry_i (l_entry),
      .right_valid_i(r_valid),
      .right_entry_i(r_entry),
      .ahead_o      (ahead[i]),
      .valid_o      (valid[i]),
      .entry_o      (entry[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    status_d  = tksq_pkg::STAT_DONE;
    removed_d = '0;
    if (ctrl.push) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d   = count_q - 1'b1;
      removed_d = entry[0];
    end else if (mode_i == tksq_pkg::MODE_ENQ) begin
      status_d = tksq_pkg::STAT_FULL;
    end else begin
      status_d = tksq_pkg::STAT_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= tksq_pkg::OCC_W'(count_d);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_tag_o      = removed_q.tag;
  assign removed_priority_o = removed_q.prio;
  assign removed_duration_o = removed_q.dur;
  assign occupancy_o        = occ_q;

endmodule

>>> src/tksq_cell.sv
// One slot of the sorted queue: holds an entry, compares and shifts.
`timescale 1ns / 1ps

module tksq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tksq_pkg::ctrl_t ctrl_i,
  input  logic            left_ahead_i,
  input  logic            left_valid_i,
  input  tksq_pkg::entry_t left_entry_i,
  input  logic            right_valid_i,
  input  tksq_pkg::entry_t right_entry_i,
  output logic            ahead_o,
  output logic            valid_o,
  output tksq_pkg::entry_t entry_o
);

  logic             valid_q, valid_d;
  tksq_pkg::entry_t entry_q, entry_d;

  // strictly ahead of the new entry: new one goes behind this slot
  assign ahead_o = valid_q &&
                   ((entry_q.prio < ctrl_i.ent.prio) ||
                    ((entry_q.prio == ctrl_i.ent.prio) && (entry_q.dur < ctrl_i.ent.dur)));

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.push) begin
      valid_d = valid_q | left_valid_i;
      if (!ahead_o) begin
        entry_d = left_ahead_i ? ctrl_i.ent : left_entry_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

>>> src/tksq_checker.sv
// Port-level checks for the two-key sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module tksq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [tksq_pkg::STA_W-1:0] status_o,
  input logic [tksq_pkg::TAG_W-1:0] removed_tag_o,
  input logic [tksq_pkg::PRI_W-1:0] removed_priority_o,
  input logic [tksq_pkg::DUR_W-1:0] removed_duration_o,
  input logic [tksq_pkg::OCC_W-1:0] occupancy_o
);

  // every transfer in gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after input transfer");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  // refused or empty operations carry no entry
  a_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != tksq_pkg::STAT_DONE |->
      removed_tag_o == '0 && removed_priority_o == '0 && removed_duration_o == '0)
    else $error("removed entry on failed operation");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tksq_pkg::STAT_FULL |->
      occupancy_o == tksq_pkg::OCC_W'(tksq_pkg::QUEUE_DEPTH))
    else $error("full status with wrong occupancy");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tksq_pkg::STAT_EMPTY |-> occupancy_o == '0)
    else $error("empty status with non-zero occupancy");

endmodule

bind two_key_sorted_priority_queue tksq_checker u_tksq_checker (.*);
